@@ rtl/lesf_pkg.sv @@
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared widths, register indexes and the obstacle reset value for the largest
// empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

	localparam int BYTE_W     = 8;
	localparam int SIZE_W     = 13;
	localparam int POS_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE  = 2'd2;

	localparam logic [BYTE_W-1:0] OBSTACLE_RESET = 8'd111;

endpackage

@@ rtl/lesf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lesf_cfg_regs
// Configuration registers; map dimensions are clamped into range on write.
// ----------------------------------------------------------------------------
module lesf_cfg_regs import lesf_pkg::*; #(
	parameter int MAX_ROWS = 4096,
	parameter int MAX_COLS = 4096,
	localparam int RLW = $clog2(MAX_ROWS + 1),
	localparam int CLW = $clog2(MAX_COLS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic [RLW-1:0]        rows,
	output logic [CLW-1:0]        cols,
	output logic [BYTE_W-1:0]     obstacle
);

	logic [RLW-1:0]    rows_q;
	logic [CLW-1:0]    cols_q;
	logic [BYTE_W-1:0] obstacle_q;
	logic [RLW-1:0]    rows_clamp;
	logic [CLW-1:0]    cols_clamp;

	// zero acts as one, anything above the limit saturates
	always_comb begin
		priority if (wr_data == '0) begin
			rows_clamp = RLW'(1);
		end else if (32'(wr_data) > 32'(MAX_ROWS)) begin
			rows_clamp = RLW'(MAX_ROWS);
		end else begin
			rows_clamp = RLW'(wr_data);
		end
		priority if (wr_data == '0) begin
			cols_clamp = CLW'(1);
		end else if (32'(wr_data) > 32'(MAX_COLS)) begin
			cols_clamp = CLW'(MAX_COLS);
		end else begin
			cols_clamp = CLW'(wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= RLW'(1);
			cols_q     <= CLW'(1);
			obstacle_q <= OBSTACLE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NUM_ROWS: rows_q     <= rows_clamp;
				REG_NUM_COLS: cols_q     <= cols_clamp;
				REG_OBSTACLE: obstacle_q <= wr_data[BYTE_W-1:0];
				default: begin
					// index beyond the register list: drop
				end
			endcase
		end
	end

	assign rows     = rows_q;
	assign cols     = cols_q;
	assign obstacle = obstacle_q;

endmodule

@@ rtl/largest_empty_square_finder.sv @@
// Result: a map's last cell passes through the stage 1 registers into the result registers;
// the result is held until taken; a map's last cell waits, in_ready low, while one is untaken.
// Throughput: one map cell per cycle while in_ready is high; the line store does one read and
// one write per cycle, with the read data forwarded when consecutive cells share a column.
// Reset: counters and best square clear, registers return to defaults, then the line store
// is zeroed, every entry in turn, with in_ready low; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Streams a map cell by cell and reports the largest square with no blocked
// cell, using a min-plus-one recurrence over a one-row line store.
// ----------------------------------------------------------------------------
module largest_empty_square_finder import lesf_pkg::*; #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     cell_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SIZE_W-1:0]     square_size,
	output logic [POS_W-1:0]      top_row,
	output logic [POS_W-1:0]      left_col
);

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SW  = $clog2(MAX_COLS + 1);
	localparam int RLW = $clog2(MAX_ROWS + 1);
	localparam int CLW = $clog2(MAX_COLS + 1);

	logic [RLW-1:0]    rows;
	logic [CLW-1:0]    cols;
	logic [BYTE_W-1:0] obstacle;

	lesf_cfg_regs #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.rows    (rows),
		.cols    (cols),
		.obstacle(obstacle)
	);

	assign cfg_ready = 1'b1;

	// position of the next cell, line store clear pass
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          clr_active_q;
	logic [CW-1:0] clr_addr_q;

	// stage 1: line store read data and cell context
	logic          s1_valid_q;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;
	logic          blocked_s1;
	logic          row_end_s1;
	logic          map_end_s1;
	logic          fwd_s1;
	logic [SW-1:0] rd_data_s1;

	// recurrence state
	logic [SW-1:0]    left_q;
	logic [SW-1:0]    diag_q;
	logic [SW-1:0]    last_d_q;
	logic [SW-1:0]    best_size_q;
	logic [POS_W-1:0] best_row_q;
	logic [POS_W-1:0] best_col_q;

	logic              out_valid_q;
	logic [SIZE_W-1:0] square_size_q;
	logic [POS_W-1:0]  top_row_q;
	logic [POS_W-1:0]  left_col_q;

	logic [SW-1:0] line_mem [MAX_COLS];

	logic             accept;
	logic             stall;
	logic             s1_fire;
	logic             row_end;
	logic             map_end;
	logic [SW-1:0]    up;
	logic [SW-1:0]    lf;
	logic [SW-1:0]    dg;
	logic [SW-1:0]    m2;
	logic [SW-1:0]    m3;
	logic [SW-1:0]    d;
	logic             better;
	logic [SW-1:0]    nb_size;
	logic [POS_W-1:0] nb_row;
	logic [POS_W-1:0] nb_col;

	// hold the last cell of a map while the previous result is still waiting
	assign stall    = s1_valid_q && map_end_s1 && out_valid_q && !out_ready;
	assign s1_fire  = s1_valid_q && !stall;
	assign in_ready = !clr_active_q && !stall;
	assign accept   = in_valid && in_ready;

	assign row_end = ((CW + 1)'(col_q) + (CW + 1)'(1)) >= (CW + 1)'(cols);
	assign map_end = row_end && (((RW + 1)'(row_q) + (RW + 1)'(1)) >= (RW + 1)'(rows));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + CW'(1);
				if (clr_addr_q == CW'(MAX_COLS - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= map_end ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1       <= col_q;
			r_s1       <= row_q;
			blocked_s1 <= (cell_byte == obstacle);
			row_end_s1 <= row_end;
			map_end_s1 <= map_end;
			// the cell in stage 1 writes this column at the same edge
			fwd_s1     <= s1_fire && (c_s1 == col_q);
		end
	end

	// line store: one read, one write per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			line_mem[clr_addr_q] <= '0;
		end else if (s1_fire) begin
			line_mem[c_s1] <= d;
		end
	end

	always_comb begin
		if (r_s1 == '0) begin
			up = '0;
		end else begin
			up = fwd_s1 ? last_d_q : rd_data_s1;
		end
		lf      = (c_s1 == '0) ? '0 : left_q;
		dg      = (r_s1 == '0 || c_s1 == '0) ? '0 : diag_q;
		m2      = (up < lf) ? up : lf;
		m3      = (m2 < dg) ? m2 : dg;
		d       = blocked_s1 ? '0 : m3 + SW'(1);
		better  = d > best_size_q;
		nb_size = better ? d : best_size_q;
		nb_row  = better ? POS_W'(32'(r_s1) + 32'd1 - 32'(d)) : best_row_q;
		nb_col  = better ? POS_W'(32'(c_s1) + 32'd1 - 32'(d)) : best_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			last_d_q    <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (s1_fire) begin
			left_q   <= row_end_s1 ? '0 : d;
			diag_q   <= row_end_s1 ? '0 : up;
			last_d_q <= d;
			if (map_end_s1) begin
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				best_size_q <= nb_size;
				best_row_q  <= nb_row;
				best_col_q  <= nb_col;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && map_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && map_end_s1) begin
			square_size_q <= SIZE_W'(32'(nb_size));
			top_row_q     <= nb_row;
			left_col_q    <= nb_col;
		end
	end

	assign out_valid   = out_valid_q;
	assign square_size = square_size_q;
	assign top_row     = top_row_q;
	assign left_col    = left_col_q;

endmodule

@@ rtl/lesf_checker.sv @@
// ----------------------------------------------------------------------------
// lesf_checker
// Port-level checks on the largest empty square finder, bound to the top.
// ----------------------------------------------------------------------------
module lesf_checker import lesf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [SIZE_W-1:0]     square_size,
	input logic [POS_W-1:0]      top_row,
	input logic [POS_W-1:0]      left_col
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(square_size)
			&& $stable(top_row) && $stable(left_col))
		else $error("result changed while stalled");

	// a fresh result follows an accepted input transaction through stage 1
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding input transaction");

	// an all-blocked map reports the origin
	a_empty_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && square_size == '0 |-> top_row == '0 && left_col == '0)
		else $error("empty result with nonzero position");

	// configuration writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);

@@ bench/largest_empty_square_finder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// largest_empty_square_finder_tb
// Streams maps cell by cell into the square finder and checks each reported
// square against the directed plan or a min-plus-one recurrence model, across
// directed corner cases, random maps and random handshake pressure.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_tb;
	import lesf_pkg::*;

	localparam int MAX_COLS      = 4096;
	localparam int MAX_ROWS      = 4096;
	localparam int SCATTER_CELLS = 700;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 6000000;
	localparam int PLAN_LEN      = 31;

	// index past the end of the register list; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
	} square_t;

	typedef enum logic {DK_CFG, DK_CELL} plan_kind_e;
	typedef enum {FILL_OPEN, FILL_WALLED, FILL_LAST_OPEN, FILL_SCATTER} map_fill_e;

	typedef struct packed {
		plan_kind_e            kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] value;
		logic                  typed;
		square_t               want;
	} plan_step_t;

	localparam square_t NO_SQUARE = '0;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [BYTE_W-1:0]     cell_byte  = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [SIZE_W-1:0]     square_size;
	logic [POS_W-1:0]      top_row;
	logic [POS_W-1:0]      left_col;

	largest_empty_square_finder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_byte  (cell_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.square_size(square_size),
		.top_row    (top_row),
		.left_col   (left_col)
	);

	// model state
	logic [CFG_DATA_W-1:0] rows_reg;
	logic [CFG_DATA_W-1:0] cols_reg;
	logic [BYTE_W-1:0]     obst_reg;
	logic [SIZE_W-1:0]     line_sizes [MAX_COLS];
	logic [SIZE_W-1:0]     left_sz;
	logic [SIZE_W-1:0]     diag_sz;
	logic [SIZE_W-1:0]     best_sz;
	logic [POS_W-1:0]      row_pos;
	logic [POS_W-1:0]      col_pos;
	logic [POS_W-1:0]      best_r;
	logic [POS_W-1:0]      best_c;

	square_t pending_squares[$];
	int      cells_sent      = 0;
	int      squares_checked = 0;
	int      mismatch_count  = 0;
	int      cycle_count     = 0;
	bit      sender_steady   = 1'b0;
	bit      hold_req        = 1'b0;

	plan_step_t directed_plan [PLAN_LEN] = '{
		// defaults after reset: one cell map, obstacle 111
		'{DK_CELL, '0, 13'd111, 1'b1, '{13'd0, 12'd0, 12'd0}},
		'{DK_CELL, '0, 13'd0,   1'b1, '{13'd1, 12'd0, 12'd0}},
		'{DK_CELL, '0, 13'd255, 1'b1, '{13'd1, 12'd0, 12'd0}},
		'{DK_CFG,  REG_UNUSED,   13'd8191, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd111, 1'b1, '{13'd0, 12'd0, 12'd0}},
		// zero sizes act as one
		'{DK_CFG,  REG_OBSTACLE, 13'd0,    1'b0, NO_SQUARE},
		'{DK_CFG,  REG_NUM_ROWS, 13'd0,    1'b0, NO_SQUARE},
		'{DK_CFG,  REG_NUM_COLS, 13'd0,    1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd0,   1'b1, '{13'd0, 12'd0, 12'd0}},
		'{DK_CELL, '0, 13'd111, 1'b1, '{13'd1, 12'd0, 12'd0}},
		// 2x3 maps: open (tie keeps the first corner), walled, corner blocked
		'{DK_CFG,  REG_OBSTACLE, 13'd255,  1'b0, NO_SQUARE},
		'{DK_CFG,  REG_NUM_ROWS, 13'd2,    1'b0, NO_SQUARE},
		'{DK_CFG,  REG_NUM_COLS, 13'd3,    1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd46,  1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd65,  1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd0,   1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd1,   1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd128, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd127, 1'b1, '{13'd2, 12'd0, 12'd0}},
		'{DK_CELL, '0, 13'd255, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd255, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd255, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd255, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd255, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd255, 1'b1, '{13'd0, 12'd0, 12'd0}},
		'{DK_CELL, '0, 13'd255, 1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd46,  1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd46,  1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd46,  1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd46,  1'b0, NO_SQUARE},
		'{DK_CELL, '0, 13'd46,  1'b1, '{13'd2, 12'd0, 12'd1}}
	};

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int clamp_dim(input int v, input int limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_span();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [BYTE_W-1:0] make_cell(input map_fill_e fill, input int pct,
		input bit last);
		logic [BYTE_W-1:0] b;
		bit                blocked;
		case (fill)
			FILL_OPEN:      blocked = 1'b0;
			FILL_WALLED:    blocked = 1'b1;
			FILL_LAST_OPEN: blocked = !last;
			default:        blocked = ($urandom_range(0, 99) < pct);
		endcase
		if (blocked)
			return obst_reg;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == obst_reg);
		return b;
	endfunction

	task automatic clear_map();
		left_sz = '0;
		diag_sz = '0;
		row_pos = '0;
		col_pos = '0;
		best_sz = '0;
		best_r  = '0;
		best_c  = '0;
	endtask

	// one cell through the recurrence; done marks the last cell of a map
	task automatic advance_model(input logic [BYTE_W-1:0] b, output bit done,
		output square_t sq);
		int rows_eff, cols_eff, r, c, up, lf, dg, d;
		rows_eff = clamp_dim(int'(rows_reg), MAX_ROWS);
		cols_eff = clamp_dim(int'(cols_reg), MAX_COLS);
		r  = int'(row_pos);
		c  = int'(col_pos);
		up = (r == 0) ? 0 : int'(line_sizes[col_pos]);
		lf = (c == 0) ? 0 : int'(left_sz);
		dg = (r == 0 || c == 0) ? 0 : int'(diag_sz);
		d  = up;
		if (lf < d)
			d = lf;
		if (dg < d)
			d = dg;
		d = (b == obst_reg) ? 0 : d + 1;
		diag_sz             = SIZE_W'(up);
		left_sz             = SIZE_W'(d);
		line_sizes[col_pos] = SIZE_W'(d);
		// only a strictly larger square replaces the best
		if (d > int'(best_sz)) begin
			best_sz = SIZE_W'(d);
			best_r  = POS_W'(r + 1 - d);
			best_c  = POS_W'(c + 1 - d);
		end
		done = 1'b0;
		sq   = NO_SQUARE;
		if (c + 1 >= cols_eff) begin
			col_pos = '0;
			left_sz = '0;
			diag_sz = '0;
			if (r + 1 >= rows_eff) begin
				done    = 1'b1;
				sq.size = best_sz;
				sq.row  = best_r;
				sq.col  = best_c;
				clear_map();
			end else begin
				row_pos = POS_W'(r + 1);
			end
		end else begin
			col_pos = POS_W'(c + 1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_NUM_ROWS: rows_reg = data;
			REG_NUM_COLS: cols_reg = data;
			REG_OBSTACLE: obst_reg = data[BYTE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_cell(input logic [BYTE_W-1:0] b, input bit typed,
		input square_t want);
		square_t sq;
		bit      done;
		int      gap;
		@(negedge clk);
		in_valid  = 1'b1;
		cell_byte = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_model(b, done, sq);
		cells_sent++;
		if (done)
			pending_squares.push_back(typed ? want : sq);
		gap = sender_steady ? 0 : idle_span();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop valid and wait until every square has come back
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_squares.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int        phase;
		int        scatter_cells;
		int        n_maps;
		int        n_cells;
		int        pct;
		bit        big;
		map_fill_e fill;
		logic [CFG_DATA_W-1:0] nr;
		logic [CFG_DATA_W-1:0] nc;
		logic [CFG_DATA_W-1:0] obs;

		rows_reg = 13'd1;
		cols_reg = 13'd1;
		obst_reg = OBSTACLE_RESET;
		foreach (line_sizes[i])
			line_sizes[i] = '0;
		clear_map();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (directed_plan[i].kind == DK_CFG) begin
				settle();
				write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
			end else begin
				send_cell(directed_plan[i].value[BYTE_W-1:0], directed_plan[i].typed,
					directed_plan[i].want);
			end
		end

		phase         = 0;
		scatter_cells = 0;
		while (scatter_cells < SCATTER_CELLS || phase < 15) begin
			settle();
			big  = 1'b1;
			fill = FILL_SCATTER;
			pct  = 90;
			case (phase)
				2: begin
					nr   = 13'd1;
					nc   = 13'd100;
					fill = FILL_LAST_OPEN;
				end
				5: begin
					nr   = 13'd100;
					nc   = 13'd1;
					fill = FILL_LAST_OPEN;
				end
				8: begin
					nr   = 13'd10;
					nc   = 13'd10;
					fill = FILL_OPEN;
				end
				11: begin
					nr = 13'd0;
					nc = 13'd50;
				end
				14: begin
					nr = 13'd50;
					nc = 13'd0;
				end
				3: begin
					big = 1'b0;
					nr  = 13'd1;
					nc  = 13'd1;
				end
				default: begin
					big = 1'b0;
					nr  = ($urandom_range(0, 9) == 0) ? '0
						: CFG_DATA_W'($urandom_range(1, 8));
					nc  = ($urandom_range(0, 9) == 0) ? '0
						: CFG_DATA_W'($urandom_range(1, 12));
				end
			endcase
			case ($urandom_range(0, 9))
				0:       obs = 13'd0;
				1:       obs = 13'd255;
				default: obs = CFG_DATA_W'($urandom_range(0, 255));
			endcase
			write_reg(REG_NUM_ROWS, nr);
			write_reg(REG_NUM_COLS, nc);
			write_reg(REG_OBSTACLE, obs);

			n_maps = big ? 1 : $urandom_range(1, 6);
			if (phase == 3) begin
				// keep offering one-cell maps while the output is held off
				n_maps   = 40;
				hold_req = 1'b1;
			end
			n_cells = clamp_dim(int'(nr), MAX_ROWS) * clamp_dim(int'(nc), MAX_COLS);
			for (int m = 0; m < n_maps; m++) begin
				sender_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
				if (!big) begin
					case ($urandom_range(0, 19))
						0:       fill = FILL_OPEN;
						1:       fill = FILL_WALLED;
						default: fill = FILL_SCATTER;
					endcase
					pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
						: $urandom_range(0, 30);
				end
				for (int k = 0; k < n_cells; k++) begin
					send_cell(make_cell(fill, pct, k == n_cells - 1), 1'b0, NO_SQUARE);
					if (!big)
						scatter_cells++;
				end
			end
			phase++;
		end

		settle();
		$display("covered %0d map cells over %0d register settings, %0d squares compared",
			cells_sent, phase + 4, squares_checked);
		$display("maps ranged from one cell to 100-cell rows and columns and a 10x10 open field");
		if (mismatch_count == 0 && pending_squares.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// output side: random stalls, steady stretches, one long hold-off
	initial begin : receiver
		int stall_left;
		int held;
		bit ready_steady;
		stall_left   = 0;
		held         = 0;
		ready_steady = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				held++;
				if (held >= LONG_HOLD) begin
					hold_req = 1'b0;
					held     = 0;
				end
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!ready_steady && $urandom_range(0, 3) == 0)
					stall_left = idle_span();
			end
			if ($urandom_range(0, 199) == 0)
				ready_steady = !ready_steady;
		end
	end

	always @(posedge clk) begin : take_square
		square_t want;
		square_t got;
		got = '{square_size, top_row, left_col};
		if (arst_n && out_valid && out_ready) begin
			squares_checked++;
			if (pending_squares.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected square: size %0d row %0d col %0d",
						got.size, got.row, got.col);
			end else begin
				want = pending_squares.pop_front();
				if (want.size !== got.size || want.row !== got.row || want.col !== got.col) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("square mismatch: expected %0d @(%0d,%0d), got %0d @(%0d,%0d)",
							want.size, want.row, want.col, got.size, got.row, got.col);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d squares outstanding", cycle_count,
			pending_squares.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
